/* hw/rtl/mmx_pkg.sv */
// Shared constants and types for the modular exponentiation block.
package mmx_pkg;

    // Default datapath width and field widths
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_W           = 32;

    // Configuration register reset values
    localparam logic [FIELD_W-1:0] EXP_RESET = 32'd17;
    localparam logic [FIELD_W-1:0] MOD_RESET = 32'd3233;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_EXPONENT = 1'b0;
    localparam t_cfg_idx REG_MODULUS  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_BIT,
        ST_MUL_WAIT,
        ST_SQR_WAIT,
        ST_OUT
    } t_state;

endpackage

/* hw/rtl/mmx_mulmod.sv */
// Bit-serial shift-add modular multiplier: one multiplier bit per cycle.
module mmx_mulmod #(
    parameter int W = mmx_pkg::OPERAND_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_prod
);

    localparam int CW = $clog2(W);

    logic          r_run;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_m;
    logic [W:0]    r_m2;
    logic [W-1:0]  r_acc;

    logic [W+1:0]  s_sum;
    logic [W+1:0]  s_m1;
    logic [W+1:0]  s_m2;
    logic [W+1:0]  s_red;
    logic [W-1:0]  n_acc;

    // Form 2*acc + bit*a, then fold it back below m (sum stays under 3m)
    always_comb begin
        s_sum = {1'b0, r_acc, 1'b0} + ({2'b00, r_a} & {(W+2){r_b[W-1]}});
        s_m1  = {2'b00, r_m};
        s_m2  = {1'b0, r_m2};
        if (s_sum >= s_m2) begin
            s_red = s_sum - s_m2;
        end else if (s_sum >= s_m1) begin
            s_red = s_sum - s_m1;
        end else begin
            s_red = s_sum;
        end
        n_acc = s_red[W-1:0];
    end

    // Control: count down the multiplier bits, pulse done after the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_run && (r_cnt == '0);
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // Datapath: load operands, then shift the multiplier MSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_m2  <= {i_m, 1'b0};
            r_acc <= '0;
        end else if (r_run) begin
            r_acc <= n_acc;
            r_b   <= {r_b[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* hw/rtl/modular_exponentiation.sv */
// Top level: right-to-left square-and-multiply modular exponentiation.
//
// Pulse i_start while busy is low to hand in one base value; the result
// appears on o_power_result for exactly one cycle with o_done high, and the
// receiver must take it then. One bit-serial modular multiplier does all the
// work. An item costs one product to reduce the base, then for each exponent
// bit up to the highest set one a bit step and a square plus, where the bit is
// one, a multiply. A modulus below two returns 0 in the cycle after the beat;
// a zero exponent still reduces the base first. Write exponent (index 0) and
// modulus (index 1) only while busy is low.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = mmx_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  mmx_pkg::t_cfg_idx            i_cfg_index,
    input  logic [mmx_pkg::FIELD_W-1:0]  i_cfg_data,
    input  logic                         i_start,
    input  logic [mmx_pkg::FIELD_W-1:0]  i_base_value,
    output logic                         busy,
    output logic                         o_done,
    output logic [mmx_pkg::FIELD_W-1:0]  o_power_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int FW = mmx_pkg::FIELD_W;

    mmx_pkg::t_state r_state;
    mmx_pkg::t_state n_state;

    logic [FW-1:0] r_exp_cfg;
    logic [FW-1:0] r_mod_cfg;
    logic [W-1:0]  r_e;
    logic [W-1:0]  r_sq;
    logic [W-1:0]  r_res;

    logic [W+FW-1:0] s_exp_ext;
    logic [W+FW-1:0] s_mod_ext;
    logic [W+FW-1:0] s_base_ext;
    logic [W+FW-1:0] s_res_ext;
    logic [W-1:0]    s_exp_w;
    logic [W-1:0]    s_mod_w;
    logic [W-1:0]    s_base_w;
    logic            s_small_mod;
    logic            s_accept;

    logic            mul_start;
    logic [W-1:0]    mul_a;
    logic [W-1:0]    mul_b;
    logic            mul_done;
    logic [W-1:0]    mul_prod;

    // Fit 32-bit fields to the datapath width
    always_comb begin
        s_exp_ext  = {{W{1'b0}}, r_exp_cfg};
        s_mod_ext  = {{W{1'b0}}, r_mod_cfg};
        s_base_ext = {{W{1'b0}}, i_base_value};
        s_res_ext  = {{FW{1'b0}}, r_res};
        s_exp_w    = s_exp_ext[W-1:0];
        s_mod_w    = s_mod_ext[W-1:0];
        s_base_w   = s_base_ext[W-1:0];
    end

    assign s_small_mod = (s_mod_w[W-1:1] == '0);
    assign s_accept    = i_start && (r_state == mmx_pkg::ST_IDLE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_cfg <= mmx_pkg::EXP_RESET;
            r_mod_cfg <= mmx_pkg::MOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mmx_pkg::REG_EXPONENT: r_exp_cfg <= i_cfg_data;
                mmx_pkg::REG_MODULUS:  r_mod_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mmx_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = s_small_mod ? mmx_pkg::ST_OUT : mmx_pkg::ST_REDUCE;
                end
            end
            mmx_pkg::ST_REDUCE: begin
                if (mul_done) begin
                    n_state = mmx_pkg::ST_BIT;
                end
            end
            mmx_pkg::ST_BIT: begin
                if (r_e == '0) begin
                    n_state = mmx_pkg::ST_OUT;
                end else if (r_e[0]) begin
                    n_state = mmx_pkg::ST_MUL_WAIT;
                end else begin
                    n_state = mmx_pkg::ST_SQR_WAIT;
                end
            end
            mmx_pkg::ST_MUL_WAIT: begin
                if (mul_done) begin
                    n_state = mmx_pkg::ST_SQR_WAIT;
                end
            end
            mmx_pkg::ST_SQR_WAIT: begin
                if (mul_done) begin
                    n_state = mmx_pkg::ST_BIT;
                end
            end
            mmx_pkg::ST_OUT: begin
                n_state = mmx_pkg::ST_IDLE;
            end
            default: begin
                n_state = mmx_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: busy, done, multiplier launches and operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_a     = r_sq;
        mul_b     = r_sq;
        busy      = 1'b1;
        o_done    = 1'b0;
        case (r_state)
            mmx_pkg::ST_IDLE: begin
                busy      = 1'b0;
                mul_start = i_start && !s_small_mod;
                mul_a     = {{(W-1){1'b0}}, 1'b1};
                mul_b     = s_base_w;
            end
            mmx_pkg::ST_BIT: begin
                mul_start = (r_e != '0);
                if (r_e[0]) begin
                    mul_a = r_res;
                end
            end
            mmx_pkg::ST_MUL_WAIT: begin
                mul_start = mul_done;
            end
            mmx_pkg::ST_OUT: begin
                o_done = 1'b1;
            end
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmx_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working values: exponent shifter, current square, running result
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_e   <= s_exp_w;
            r_res <= s_small_mod ? '0 : {{(W-1){1'b0}}, 1'b1};
        end
        case (r_state)
            mmx_pkg::ST_REDUCE: begin
                if (mul_done) begin
                    r_sq <= mul_prod;
                end
            end
            mmx_pkg::ST_MUL_WAIT: begin
                if (mul_done) begin
                    r_res <= mul_prod;
                end
            end
            mmx_pkg::ST_SQR_WAIT: begin
                if (mul_done) begin
                    r_sq <= mul_prod;
                    r_e  <= {1'b0, r_e[W-1:1]};
                end
            end
            default: ;
        endcase
    end

    mmx_mulmod #(
        .W (W)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (s_mod_w),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign o_power_result = s_res_ext[FW-1:0];

endmodule

/* hw/rtl/mmx_checker.sv */
// Port-level checker for the modular exponentiation block, with its bind.
module mmx_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic busy,
    input logic o_done
);

    // An accepted beat keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !busy) |=> busy)
        else $error("block not busy after accepted beat");

    // A result beat comes only while busy
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result beat while idle");

    // A result beat lasts one cycle and frees the block
    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result beat not followed by idle");

    // Busy drops only after a result beat
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> $past(o_done))
        else $error("busy dropped without a result beat");

endmodule

bind modular_exponentiation mmx_checker u_mmx_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .busy    (busy),
    .o_done  (o_done)
);

/* bench/tb.sv */
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 100ps

module tb;

    localparam int  FIELD_W     = mmx_pkg::FIELD_W;
    localparam int  CYCLE_LIMIT = 4_000_000;
    localparam int  RAND_PHASES = 12;
    localparam int  PHASE_BASES = 23;

    // One directed row: key setting, base and, where obvious, the known power
    typedef struct {
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
        logic [FIELD_W-1:0] base;
        bit                 known;
        logic [FIELD_W-1:0] power;
    } t_vector;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    mmx_pkg::t_cfg_idx   i_cfg_index;
    logic [FIELD_W-1:0]  i_cfg_data;
    logic                i_start;
    logic [FIELD_W-1:0]  i_base_value;
    logic                busy;
    logic                o_done;
    logic [FIELD_W-1:0]  o_power_result;

    logic [FIELD_W-1:0]  key_exponent;
    logic [FIELD_W-1:0]  key_modulus;
    logic [FIELD_W-1:0]  pending_powers[$];
    int                  error_count;
    int                  bases_sent;
    int                  powers_checked;
    int                  key_loads;
    int                  cycle_count;

    t_vector directed_vectors[] = '{
        '{32'd17,         32'd3233,       32'd65,         1'b1, 32'd2790},
        '{32'd17,         32'd3233,       32'd0,          1'b1, 32'd0},
        '{32'd17,         32'd3233,       32'd1,          1'b1, 32'd1},
        '{32'd17,         32'd3233,       32'd3233,       1'b1, 32'd0},
        '{32'd17,         32'd3233,       32'd3298,       1'b1, 32'd2790},
        '{32'd17,         32'd3233,       32'hFFFF_FFFF,  1'b0, 32'd0},
        '{32'd2753,       32'd3233,       32'd2790,       1'b1, 32'd65},
        '{32'd0,          32'd3233,       32'd12345,      1'b1, 32'd1},
        '{32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd1},
        '{32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE},
        '{32'd2,          32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b1, 32'd1},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0},
        '{32'hFFFF_FFFA,  32'hFFFF_FFFB,  32'd2,          1'b1, 32'd1},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFB,  32'hDEAD_BEEF,  1'b0, 32'd0},
        '{32'd5,          32'd2,          32'd7,          1'b1, 32'd1},
        '{32'd5,          32'd2,          32'd8,          1'b1, 32'd0},
        '{32'd7,          32'd1,          32'd9,          1'b1, 32'd0},
        '{32'd7,          32'd0,          32'd9,          1'b1, 32'd0},
        '{32'd0,          32'd0,          32'd9,          1'b1, 32'd0},
        '{32'h8000_0000,  32'h7FFF_FFFF,  32'd3,          1'b0, 32'd0},
        '{32'h1234_5678,  32'h9ABC_DEF1,  32'h8000_0000,  1'b0, 32'd0}
    };

    modular_exponentiation dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .i_base_value   (i_base_value),
        .busy           (busy),
        .o_done         (o_done),
        .o_power_result (o_power_result)
    );

    // Run the clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // base ^ exponent mod modulus, right to left; products are exact at 64 bits
    function automatic logic [FIELD_W-1:0] predict_power(input logic [FIELD_W-1:0] base,
                                                         input logic [FIELD_W-1:0] exponent,
                                                         input logic [FIELD_W-1:0] modulus);
        logic [63:0] acc;
        logic [63:0] square;
        logic [63:0] m;
        m = {32'd0, modulus};
        if (m < 2) begin
            return '0;
        end
        square = {32'd0, base} % m;
        acc    = 64'd1;
        for (int i = 0; i < FIELD_W; i++) begin
            if (exponent[i]) begin
                acc = (acc * square) % m;
            end
            square = (square * square) % m;
        end
        return acc[FIELD_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] want,
                                   input logic [FIELD_W-1:0] got);
        $display("[%0t] ERROR %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
        error_count++;
    endtask

    // Check each power beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_powers.size() == 0) begin
                report_mismatch("power_result with nothing pending", '0, o_power_result);
            end else begin
                if (o_power_result !== pending_powers[0]) begin
                    report_mismatch("power_result", pending_powers[0], o_power_result);
                end
                void'(pending_powers.pop_front());
                powers_checked++;
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d powers pending", $time, pending_powers.size());
            $display("modular_exponentiation: mismatch");
            $finish;
        end
    end

    // Hand in one base at a falling edge and hold it until accepted
    task automatic send_base(input logic [FIELD_W-1:0] base, input bit known,
                             input logic [FIELD_W-1:0] power);
        i_start      <= 1'b1;
        i_base_value <= base;
        do @(posedge i_clk); while (busy);
        if (known) begin
            pending_powers.push_back(power);
        end else begin
            pending_powers.push_back(predict_power(base, key_exponent, key_modulus));
        end
        bases_sent++;
        @(negedge i_clk);
    endtask

    // Drop start for a while
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            i_start <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until every pending power is back and the block is idle
    task automatic drain;
        i_start <= 1'b0;
        while (pending_powers.size() != 0) @(negedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (4) @(negedge i_clk);
    endtask

    // Write both key registers while idle
    task automatic load_keys(input logic [FIELD_W-1:0] exponent,
                             input logic [FIELD_W-1:0] modulus);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mmx_pkg::REG_EXPONENT;
        i_cfg_data  <= exponent;
        @(negedge i_clk);
        i_cfg_index <= mmx_pkg::REG_MODULUS;
        i_cfg_data  <= modulus;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        key_exponent = exponent;
        key_modulus  = modulus;
        key_loads++;
    endtask

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap;
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 8);
        if (r < 97) return $urandom_range(9, 300);
        return $urandom_range(301, 2500);
    endfunction

    // Bases: full range, already reduced, near the modulus, tiny
    function automatic logic [FIELD_W-1:0] pick_base;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return (key_modulus == 0) ? $urandom : $urandom % key_modulus;
            2: return key_modulus + $urandom_range(0, 4) - 2;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    // Stimulus
    initial begin
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = mmx_pkg::REG_EXPONENT;
        i_cfg_data   = '0;
        i_start      = 1'b0;
        i_base_value = '0;
        key_exponent = mmx_pkg::EXP_RESET;
        key_modulus  = mmx_pkg::MOD_RESET;
        error_count  = 0;
        bases_sent   = 0;
        powers_checked = 0;
        key_loads    = 0;
        cycle_count  = 0;

        // Reset
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table; reload keys only when the row changes them
        foreach (directed_vectors[k]) begin
            if (directed_vectors[k].exponent !== key_exponent ||
                directed_vectors[k].modulus !== key_modulus) begin
                load_keys(directed_vectors[k].exponent, directed_vectors[k].modulus);
            end
            send_base(directed_vectors[k].base, directed_vectors[k].known,
                      directed_vectors[k].power);
            hold_off(pick_gap());
        end

        // Random key settings, each with a run of bases
        for (int p = 0; p < RAND_PHASES; p++) begin
            exponent = $urandom >> $urandom_range(0, 31);
            modulus  = $urandom >> $urandom_range(0, 30);
            if (p == 0) begin
                exponent = 32'hFFFF_FFFF;
                modulus  = $urandom | 32'h8000_0000;
            end else if ($urandom_range(0, 11) == 0) begin
                exponent = '0;
            end
            if (modulus < 2) modulus = 2;
            if (p != 0 && $urandom_range(0, 15) == 0) modulus = $urandom_range(0, 1);
            load_keys(exponent, modulus);
            for (int n = 0; n < PHASE_BASES; n++) begin
                // Pause now and then until the block has caught up
                if ((p == 1 && n == PHASE_BASES / 2) || $urandom_range(0, 29) == 0) begin
                    drain();
                end
                send_base(pick_base(), 1'b0, '0);
                if (p % 3 != 2) begin
                    hold_off(pick_gap());
                end
            end
        end

        // Wait out the tail
        i_start <= 1'b0;
        while (pending_powers.size() != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("covered %0d bases (%0d from the table) across %0d key loads",
                 bases_sent, directed_vectors.size(), key_loads);
        $display("checked %0d powers, %0d errors", powers_checked, error_count);
        if (error_count == 0 && pending_powers.size() == 0) begin
            $display("modular_exponentiation: match");
        end else begin
            $display("modular_exponentiation: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mmx_pkg.sv
hw/rtl/mmx_mulmod.sv
hw/rtl/modular_exponentiation.sv
hw/rtl/mmx_checker.sv
bench/tb.sv
